[rtl/clr_pkg.sv]
// Shared constants, register codes and the viewport struct of the clipped line rasterizer.
`timescale 1ns / 1ps

package clr_pkg;

    // Fixed field widths of the ports.
    localparam int IN_COORD_W  = 6;
    localparam int GLYPH_W     = 16;
    localparam int COLOUR_W    = 8;
    localparam int SCREEN_W    = 10;
    localparam int VIEW_POS_W  = 8;
    localparam int VIEW_SIZE_W = 9;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    // Defaults for the top-level parameters.
    localparam int COORD_BITS_DEF  = 6;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [VIEW_SIZE_W-1:0] VIEW_SIZE_RESET = VIEW_SIZE_W'(32);

    typedef enum logic [1:0] {
        REG_VIEW_LEFT   = 2'd0,
        REG_VIEW_TOP    = 2'd1,
        REG_VIEW_WIDTH  = 2'd2,
        REG_VIEW_HEIGHT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [VIEW_POS_W-1:0]  left;
        logic [VIEW_POS_W-1:0]  top;
        logic [VIEW_SIZE_W-1:0] width;
        logic [VIEW_SIZE_W-1:0] height;
    } t_view;

    // Handshake status of the line queue as seen by the front end and the walker.
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage

[rtl/clr_front.sv]
// Front end: takes a line command, sign extends the endpoints and works out the slope terms.
`timescale 1ns / 1ps

module clr_front
    import clr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int DESC_W    = 6 * COORD_BITS + 2 + GLYPH_W + 1 + COLOUR_W
) (
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [IN_COORD_W-1:0] i_start_x,
    input  logic [IN_COORD_W-1:0] i_start_y,
    input  logic [IN_COORD_W-1:0] i_end_x,
    input  logic [IN_COORD_W-1:0] i_end_y,
    input  logic [GLYPH_W-1:0]    i_glyph_code,
    input  logic                  i_glyph_wide,
    input  logic [COLOUR_W-1:0]   i_colour,
    input  t_queue_status         i_q_status,
    output logic                  o_push,
    output logic [DESC_W-1:0]     o_desc
);

    logic signed [COORD_BITS-1:0] x0, y0, x1, y1;
    logic signed [COORD_BITS:0]   dx, dy;
    logic [COORD_BITS-1:0]        adx, ady;
    logic                         sx_neg, sy_neg;

    // Only the low coordinate bits count; the top one of them is the sign.
    assign x0 = i_start_x[COORD_BITS-1:0];
    assign y0 = i_start_y[COORD_BITS-1:0];
    assign x1 = i_end_x[COORD_BITS-1:0];
    assign y1 = i_end_y[COORD_BITS-1:0];

    assign dx = (COORD_BITS+1)'(x1) - (COORD_BITS+1)'(x0);
    assign dy = (COORD_BITS+1)'(y1) - (COORD_BITS+1)'(y0);

    always_comb begin
        adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    end

    // A step is negative unless the start lies strictly below the end.
    assign sx_neg = !(x0 < x1);
    assign sy_neg = !(y0 < y1);

    assign o_ready = !i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;
    assign o_desc  = {x0, y0, x1, y1, adx, ady, sx_neg, sy_neg,
                      i_glyph_code, i_glyph_wide, i_colour};

endmodule

[rtl/clr_queue.sv]
// Small register queue that holds prepared line descriptors between front and walker.
`timescale 1ns / 1ps

module clr_queue
    import clr_pkg::*;
#(
    parameter int DW    = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output t_queue_status o_status
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        next_ptr = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= next_ptr(r_wr);
            end
            if (i_pop) begin
                r_rd <= next_ptr(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CW'(DEPTH));

endmodule

[rtl/clr_walker.sv]
// Back end: walks one line a point per cycle unless stalled and registers each clipped point for output.
`timescale 1ns / 1ps

module clr_walker
    import clr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int DESC_W    = 6 * COORD_BITS + 2 + GLYPH_W + 1 + COLOUR_W,
    localparam int ERR_W     = COORD_BITS + 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_view                      i_view,
    input  t_queue_status              i_q_status,
    input  logic [DESC_W-1:0]          i_desc,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SCREEN_W-1:0] o_screen_col,
    output logic signed [SCREEN_W-1:0] o_screen_row,
    output logic [GLYPH_W-1:0]         o_glyph_out,
    output logic [COLOUR_W-1:0]        o_colour_out,
    output logic                       o_write_enable,
    output logic                       o_last_point
);

    logic signed [COORD_BITS-1:0] d_x0, d_y0, d_x1, d_y1;
    logic [COORD_BITS-1:0]        d_adx, d_ady;
    logic                         d_sxn, d_syn;
    logic [GLYPH_W-1:0]           d_glyph;
    logic                         d_wide;
    logic [COLOUR_W-1:0]          d_colour;

    logic                         r_busy;
    logic signed [COORD_BITS-1:0] r_x, r_y, r_x1, r_y1;
    logic signed [ERR_W-1:0]      r_err;
    logic [COORD_BITS-1:0]        r_adx, r_ady;
    logic                         r_sxn, r_syn;
    logic [GLYPH_W-1:0]           r_glyph;
    logic                         r_wide;
    logic [COLOUR_W-1:0]          r_colour;

    logic                         r_out_valid;
    logic signed [SCREEN_W-1:0]   r_col, r_row;
    logic [GLYPH_W-1:0]           r_glyph_o;
    logic [COLOUR_W-1:0]          r_colour_o;
    logic                         r_we, r_last;

    logic                         advance, emit, is_last;
    logic signed [ERR_W-1:0]      e2, pos_dx, neg_dy, n_err;
    logic                         step_x, step_y;
    logic signed [COORD_BITS-1:0] n_x, n_y;
    logic [VIEW_SIZE_W:0]         x_wide, y_wide;
    logic                         visible, we;

    assign {d_x0, d_y0, d_x1, d_y1, d_adx, d_ady, d_sxn, d_syn,
            d_glyph, d_wide, d_colour} = i_desc;

    assign advance = !r_out_valid || i_ready;
    assign emit    = r_busy && advance;
    assign o_pop   = !r_busy && !i_q_status.empty;
    assign is_last = (r_x == r_x1) && (r_y == r_y1);

    // Error update of the all-octant rule; both tests use the error before this step.
    always_comb begin
        pos_dx = ERR_W'(r_adx);
        neg_dy = -ERR_W'(r_ady);
        e2     = r_err <<< 1;
        step_x = (e2 >= neg_dy);
        step_y = (e2 <= pos_dx);
        n_err  = r_err + (step_x ? neg_dy : '0) + (step_y ? pos_dx : '0);
        n_x    = step_x ? (r_sxn ? r_x - 1'b1 : r_x + 1'b1) : r_x;
        n_y    = step_y ? (r_syn ? r_y - 1'b1 : r_y + 1'b1) : r_y;
    end

    // Clip test on the viewport-relative point; a negative coordinate is never visible.
    always_comb begin
        x_wide  = (VIEW_SIZE_W+1)'(unsigned'(r_x));
        y_wide  = (VIEW_SIZE_W+1)'(unsigned'(r_y));
        visible = !r_x[COORD_BITS-1] && !r_y[COORD_BITS-1]
               && (x_wide < {1'b0, i_view.width})
               && (y_wide < {1'b0, i_view.height});
        we      = visible && !(r_wide && ((x_wide + 1'b1) >= {1'b0, i_view.width}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && is_last) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_x      <= d_x0;
            r_y      <= d_y0;
            r_x1     <= d_x1;
            r_y1     <= d_y1;
            r_adx    <= d_adx;
            r_ady    <= d_ady;
            r_sxn    <= d_sxn;
            r_syn    <= d_syn;
            r_err    <= ERR_W'(d_adx) - ERR_W'(d_ady);
            r_glyph  <= d_glyph;
            r_wide   <= d_wide;
            r_colour <= d_colour;
        end else if (emit && !is_last) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_err <= n_err;
        end
        if (emit) begin
            r_col      <= SCREEN_W'(i_view.left) + SCREEN_W'(r_x);
            r_row      <= SCREEN_W'(i_view.top) + SCREEN_W'(r_y);
            r_glyph_o  <= r_glyph;
            r_colour_o <= r_colour;
            r_we       <= we;
            r_last     <= is_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_screen_col   = r_col;
    assign o_screen_row   = r_row;
    assign o_glyph_out    = r_glyph_o;
    assign o_colour_out   = r_colour_o;
    assign o_write_enable = r_we;
    assign o_last_point   = r_last;

endmodule

[rtl/clipped_line_rasterizer.sv]
// Top level of the clipped line rasterizer: viewport registers, front end, line queue, walker.
//
//   Channel  Direction  Handshake              Moves
//   command  in         i_valid / o_ready      one line: endpoints, glyph, wide flag, colour
//   point    out        o_valid / i_ready      screen position, glyph, colour, enable, last
//   config   in         psel/penable/pwrite    viewport origin and size registers
//
// A line has N points, N = max(|end_x - start_x|, |end_y - start_y|) + 1, at most 2^COORD_BITS.
// Its command passes through the queue, the walker's position registers (loaded only while the
// walker is idle) and the walker's output register before its first point is offered.
// Reset is synchronous and active low; it empties the queue, idles the walker and
// restores the viewport registers (origin 0, size 32 by 32).
// The queue holds QUEUE_DEPTH lines; a stalled point channel freezes only the walker.
`timescale 1ns / 1ps

module clipped_line_rasterizer
    import clr_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    // Command channel.
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [IN_COORD_W-1:0]      i_start_x,
    input  logic [IN_COORD_W-1:0]      i_start_y,
    input  logic [IN_COORD_W-1:0]      i_end_x,
    input  logic [IN_COORD_W-1:0]      i_end_y,
    input  logic [GLYPH_W-1:0]         i_glyph_code,
    input  logic                       i_glyph_wide,
    input  logic [COLOUR_W-1:0]        i_colour,

    // Point channel.
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SCREEN_W-1:0] o_screen_col,
    output logic signed [SCREEN_W-1:0] o_screen_row,
    output logic [GLYPH_W-1:0]         o_glyph_out,
    output logic [COLOUR_W-1:0]        o_colour_out,
    output logic                       o_write_enable,
    output logic                       o_last_point,

    // Configuration port.
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_ADDR_W-1:0]      paddr,
    input  logic [APB_DATA_W-1:0]      pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int DESC_W = 6 * COORD_BITS + 2 + GLYPH_W + 1 + COLOUR_W;

    t_view         r_view;
    t_reg_idx      reg_idx;
    t_queue_status q_status;
    logic          push, pop;
    logic [DESC_W-1:0] desc_in, desc_out;

    // Registers sit at word addresses; the word index selects the register.
    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign pready  = 1'b1;

    // Registers are written on the access cycle of a write transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view.left   <= '0;
            r_view.top    <= '0;
            r_view.width  <= VIEW_SIZE_RESET;
            r_view.height <= VIEW_SIZE_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_VIEW_LEFT:   r_view.left   <= pwdata[VIEW_POS_W-1:0];
                REG_VIEW_TOP:    r_view.top    <= pwdata[VIEW_POS_W-1:0];
                REG_VIEW_WIDTH:  r_view.width  <= pwdata[VIEW_SIZE_W-1:0];
                REG_VIEW_HEIGHT: r_view.height <= pwdata[VIEW_SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_VIEW_LEFT:   prdata = APB_DATA_W'(r_view.left);
            REG_VIEW_TOP:    prdata = APB_DATA_W'(r_view.top);
            REG_VIEW_WIDTH:  prdata = APB_DATA_W'(r_view.width);
            REG_VIEW_HEIGHT: prdata = APB_DATA_W'(r_view.height);
            default:         prdata = '0;
        endcase
    end

    // The front end prepares a descriptor in the cycle the command is transferred.
    clr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_glyph_code (i_glyph_code),
        .i_glyph_wide (i_glyph_wide),
        .i_colour     (i_colour),
        .i_q_status   (q_status),
        .o_push       (push),
        .o_desc       (desc_in)
    );

    clr_queue #(
        .DW    (DESC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (desc_in),
        .i_pop    (pop),
        .o_data   (desc_out),
        .o_status (q_status)
    );

    // The walker emits one point per cycle into its output register while the
    // point channel keeps up; the viewport is read as each point is registered.
    clr_walker #(
        .COORD_BITS (COORD_BITS)
    ) u_walker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_view         (r_view),
        .i_q_status     (q_status),
        .i_desc         (desc_out),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_screen_col   (o_screen_col),
        .o_screen_row   (o_screen_row),
        .o_glyph_out    (o_glyph_out),
        .o_colour_out   (o_colour_out),
        .o_write_enable (o_write_enable),
        .o_last_point   (o_last_point)
    );

endmodule
